/* rtl/core/dmxrdm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dmxrdm_pkg
// Shared types and constants of the DMX512 / RDM frame receiver.
// ----------------------------------------------------------------------------
package dmxrdm_pkg;

	// store depths (defaults of the top-level parameters)
	localparam int unsigned CHANNEL_DEPTH_DEF = 512;
	localparam int unsigned PACKET_DEPTH_DEF  = 256;

	localparam logic [7:0]  RDM_CODE      = 8'hCC;
	localparam logic [7:0]  DMX_CODE      = 8'h00;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [8:0]  LEN_EXTRA     = 9'd2;
	localparam logic [10:0] SLOT_MAX      = 11'h7FF;
	localparam logic [8:0]  PKT_CNT_MAX   = 9'h1FF;
	localparam logic [8:0]  PKT_LEN_IDX   = 9'd2;

	// configuration register indexes
	localparam logic [1:0] REG_START_ADDRESS = 2'd0;
	localparam logic [1:0] REG_FOOTPRINT     = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;

	typedef enum logic [2:0] {
		OP_BYTE    = 3'd0,
		OP_TICK    = 3'd1,
		OP_RD_CHAN = 3'd2,
		OP_RD_PKT  = 3'd3,
		OP_ACK     = 3'd4
	} op_t;

	// what the start code selected
	typedef enum logic [1:0] {
		SC_NONE,
		SC_DMX,
		SC_RDM
	} sc_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_BREAK = 2'd1,
		MODE_DMX   = 2'd2,
		MODE_RDM   = 2'd3
	} mode_t;

	// source of the read data of a word
	typedef enum logic [1:0] {
		RD_NONE,
		RD_CHAN,
		RD_PKT,
		RD_PKT0
	} rd_sel_t;

	typedef struct packed {
		logic  dmx_ready;
		logic  rdm_ready;
		logic  overflow;
		logic  brk;
		logic  timeout;
		mode_t mode;
	} stat_t;

endpackage
`default_nettype wire

/* rtl/core/dmx_rdm_frame_receiver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_rdm_frame_receiver
// DMX512 / RDM receiver: BREAK detection, DMX slot capture into the channel
// memory, RDM packet capture into the packet memory, tick timeout.
// ----------------------------------------------------------------------------
// An accepted word passes through stage 1 and the output register to its result word.
// Throughput: one word per cycle while in_stall is low; state updates in the accept
// cycle, memory reads are registered in stage 1, followed by the output register.
// Reset: after arst_n releases, a clearing pass zeroes every entry of both
// memories; in_stall is high meanwhile.
// Configuration writes are taken at any time (cfg_ready is always high).
module dmx_rdm_frame_receiver
	import dmxrdm_pkg::*;
#(
	parameter int unsigned CHANNEL_DEPTH = CHANNEL_DEPTH_DEF,
	parameter int unsigned PACKET_DEPTH  = PACKET_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  operation,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        framing_error,
	input  wire logic        ninth_bit,
	input  wire logic        rx_enable,
	input  wire logic [8:0]  read_index,
	input  wire logic [2:0]  clear_mask,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             dmx_frame_ready,
	output logic             rdm_packet_ready,
	output logic             rdm_overflow,
	output logic             break_seen,
	output logic             timeout_error,
	output logic [1:0]       mode,
	output logic [7:0]       read_data
);

	localparam int unsigned CW = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;
	localparam int unsigned PW = $clog2(PACKET_DEPTH);
	localparam int unsigned CLR_DEPTH =
		(CHANNEL_DEPTH > PACKET_DEPTH) ? CHANNEL_DEPTH : PACKET_DEPTH;
	localparam int unsigned CLRW = $clog2(CLR_DEPTH + 1);

	// ---------------- configuration ----------------
	logic [9:0]  start_address_q;
	logic [9:0]  footprint_q;
	logic [15:0] timeout_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_address_q <= 10'd1;
			footprint_q     <= 10'd1;
			timeout_limit_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_ADDRESS: start_address_q <= cfg_data[9:0];
				REG_FOOTPRINT:     footprint_q     <= cfg_data[9:0];
				REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- memories ----------------
	logic [7:0] chan_mem [CHANNEL_DEPTH];
	logic [7:0] pkt_mem  [PACKET_DEPTH];

	// ---------------- state ----------------
	logic        in_break_q,   in_break_n;
	sc_t         sc_q,         sc_n;
	logic [10:0] slot_q,       slot_n;
	logic        dmx_done_q,   dmx_done_n;
	logic [8:0]  pcnt_q,       pcnt_n;
	logic [8:0]  plen_q,       plen_n;
	logic        ovf_q,        ovf_n;
	logic        pdone_q,      pdone_n;
	logic        sync_q,       sync_n;
	logic [16:0] tick_q,       tick_n;
	logic        tmo_q,        tmo_n;
	logic        pkt0_q,       pkt0_n;    // packet entry 0 holds the RDM code once set

	logic             clearing_q;
	logic [CLRW-1:0]  clr_q;

	// ---------------- pipeline control ----------------
	logic    valid_s1;
	stat_t   stat_s1;
	rd_sel_t sel_s1;
	logic    pkt0_s1;
	logic [7:0] chan_rd_s1;
	logic [7:0] pkt_rd_s1;

	logic    out_valid_q;
	stat_t   stat_q;
	logic [7:0] read_data_q;

	logic advance, s1_load, in_acc;

	assign advance  = !out_valid_q || !out_stall;
	assign s1_load  = !valid_s1 || advance;
	assign in_stall = clearing_q || !s1_load;
	assign in_acc   = in_valid && !in_stall;

	// ---------------- next-state logic ----------------
	logic        is_break;
	logic [10:0] slot_inc;
	logic [10:0] slot_off;
	logic [11:0] slot_off_inc;
	logic [8:0]  pcnt_inc;
	logic [8:0]  plen_new;
	logic        ovf_new;
	sc_t         sc_dec;
	rd_sel_t     sel_n;
	stat_t       stat_n;

	logic          chan_we;
	logic [CW-1:0] chan_wa;
	logic [7:0]    chan_wd;
	logic          chan_re;
	logic          pkt_we;
	logic [PW-1:0] pkt_wa;
	logic [7:0]    pkt_wd;
	logic          pkt_re;

	assign is_break = framing_error && (rx_byte == 8'h00) && !ninth_bit;

	always_comb begin
		if (rx_byte == DMX_CODE)
			sc_dec = SC_DMX;
		else if (rx_byte == RDM_CODE)
			sc_dec = SC_RDM;
		else
			sc_dec = SC_NONE;
	end

	assign slot_inc     = (slot_q < SLOT_MAX) ? slot_q + 11'd1 : slot_q;
	assign slot_off     = slot_inc - {1'b0, start_address_q};
	assign slot_off_inc = {1'b0, slot_off} + 12'd1;

	assign plen_new = (pcnt_q == PKT_LEN_IDX) ? 9'({1'b0, rx_byte} + LEN_EXTRA) : plen_q;
	assign pcnt_inc = (pcnt_q < PKT_CNT_MAX) ? pcnt_q + 9'd1 : pcnt_q;
	assign ovf_new  = ovf_q || ({1'b0, pcnt_inc} >= 10'(PACKET_DEPTH));

	always_comb begin
		in_break_n = in_break_q;
		sc_n       = sc_q;
		slot_n     = slot_q;
		dmx_done_n = dmx_done_q;
		pcnt_n     = pcnt_q;
		plen_n     = plen_q;
		ovf_n      = ovf_q;
		pdone_n    = pdone_q;
		sync_n     = sync_q;
		tick_n     = tick_q;
		tmo_n      = tmo_q;
		pkt0_n     = pkt0_q;
		sel_n      = RD_NONE;
		chan_we    = 1'b0;
		chan_wa    = slot_off[CW-1:0];
		chan_wd    = rx_byte;
		chan_re    = 1'b0;
		pkt_we     = 1'b0;
		pkt_wa     = pcnt_q[PW-1:0];
		pkt_wd     = rx_byte;
		pkt_re     = 1'b0;

		if (clearing_q) begin
			chan_we = (clr_q < CLRW'(CHANNEL_DEPTH));
			chan_wa = clr_q[CW-1:0];
			chan_wd = 8'h00;
			pkt_we  = (clr_q < CLRW'(PACKET_DEPTH));
			pkt_wa  = clr_q[PW-1:0];
			pkt_wd  = 8'h00;
		end else if (in_acc) begin
			case (op_t'(operation))
				OP_BYTE: begin
					if (is_break) begin
						in_break_n = 1'b1;
						slot_n     = 11'd0;
						tick_n     = 17'd0;
						dmx_done_n = 1'b0;
						tmo_n      = 1'b0;
						sync_n     = 1'b1;
						pcnt_n     = 9'd1;
						ovf_n      = 1'b0;
						plen_n     = 9'd0;
					end else if (in_break_q) begin
						sc_n       = sc_dec;
						in_break_n = 1'b0;
					end else if (sc_q == SC_DMX) begin
						slot_n = slot_inc;
						if (slot_inc >= {1'b0, start_address_q}) begin
							chan_we = ({1'b0, slot_off} < 12'(CHANNEL_DEPTH));
							if (slot_off_inc >= {2'b00, footprint_q}) begin
								dmx_done_n = 1'b1;
								sc_n       = SC_NONE;
							end
						end
					end else if (sc_q == SC_RDM) begin
						// entry 0 never takes a data byte: the count starts at 1
						pkt_we = ({1'b0, pcnt_q} < 10'(PACKET_DEPTH));
						pcnt_n = pcnt_inc;
						plen_n = plen_new;
						ovf_n  = ovf_new;
						if (pcnt_inc == plen_new || ovf_new) begin
							pkt0_n  = 1'b1;
							sc_n    = SC_NONE;
							pdone_n = 1'b1;
							plen_n  = 9'd0;
						end
					end
				end
				OP_TICK: begin
					if (!rx_enable) begin
						tick_n = 17'd0;
						tmo_n  = 1'b0;
					end else if (tick_q > {1'b0, timeout_limit_q}) begin
						tmo_n = 1'b1;
					end else begin
						tick_n = tick_q + 17'd1;
					end
				end
				OP_RD_CHAN: begin
					if ({1'b0, read_index} < 10'(CHANNEL_DEPTH)) begin
						chan_re = 1'b1;
						sel_n   = RD_CHAN;
					end
				end
				OP_RD_PKT: begin
					if ({1'b0, read_index} < 10'(PACKET_DEPTH)) begin
						if (read_index == 9'd0) begin
							sel_n = RD_PKT0;
						end else begin
							pkt_re = 1'b1;
							sel_n  = RD_PKT;
						end
					end
				end
				OP_ACK: begin
					if (clear_mask[0]) dmx_done_n = 1'b0;
					if (clear_mask[1]) pdone_n    = 1'b0;
					if (clear_mask[2]) sync_n     = 1'b0;
				end
				default: ;
			endcase
		end

		stat_n.dmx_ready = dmx_done_n;
		stat_n.rdm_ready = pdone_n;
		stat_n.overflow  = ovf_n;
		stat_n.brk       = sync_n;
		stat_n.timeout   = tmo_n;
		if (in_break_n)
			stat_n.mode = MODE_BREAK;
		else if (sc_n == SC_DMX)
			stat_n.mode = MODE_DMX;
		else if (sc_n == SC_RDM)
			stat_n.mode = MODE_RDM;
		else
			stat_n.mode = MODE_IDLE;
	end

	// ---------------- state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_break_q <= 1'b0;
			sc_q       <= SC_NONE;
			slot_q     <= 11'd0;
			dmx_done_q <= 1'b0;
			pcnt_q     <= 9'd0;
			plen_q     <= 9'd0;
			ovf_q      <= 1'b0;
			pdone_q    <= 1'b0;
			sync_q     <= 1'b0;
			tick_q     <= 17'd0;
			tmo_q      <= 1'b0;
			pkt0_q     <= 1'b0;
		end else begin
			in_break_q <= in_break_n;
			sc_q       <= sc_n;
			slot_q     <= slot_n;
			dmx_done_q <= dmx_done_n;
			pcnt_q     <= pcnt_n;
			plen_q     <= plen_n;
			ovf_q      <= ovf_n;
			pdone_q    <= pdone_n;
			sync_q     <= sync_n;
			tick_q     <= tick_n;
			tmo_q      <= tmo_n;
			pkt0_q     <= pkt0_n;
		end
	end

	// clearing pass over both memories after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == CLRW'(CLR_DEPTH - 1))
				clearing_q <= 1'b0;
			clr_q <= clr_q + CLRW'(1);
		end
	end

	// ---------------- memory ports ----------------
	always_ff @(posedge clk) begin
		if (chan_we)
			chan_mem[chan_wa] <= chan_wd;
		if (chan_re)
			chan_rd_s1 <= chan_mem[read_index[CW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pkt_we)
			pkt_mem[pkt_wa] <= pkt_wd;
		if (pkt_re)
			pkt_rd_s1 <= pkt_mem[read_index[PW-1:0]];
	end

	// ---------------- stage 1 and output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load)
				valid_s1 <= in_acc;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			stat_s1 <= stat_n;
			sel_s1  <= sel_n;
			pkt0_s1 <= pkt0_n;
		end
		if (advance && valid_s1) begin
			stat_q <= stat_s1;
			case (sel_s1)
				RD_CHAN: read_data_q <= chan_rd_s1;
				RD_PKT:  read_data_q <= pkt_rd_s1;
				RD_PKT0: read_data_q <= pkt0_s1 ? RDM_CODE : 8'h00;
				default: read_data_q <= 8'h00;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign dmx_frame_ready  = stat_q.dmx_ready;
	assign rdm_packet_ready = stat_q.rdm_ready;
	assign rdm_overflow     = stat_q.overflow;
	assign break_seen       = stat_q.brk;
	assign timeout_error    = stat_q.timeout;
	assign mode             = stat_q.mode;
	assign read_data        = read_data_q;

endmodule
`default_nettype wire
